// ===== design/pfb_pkg.sv =====
// Shared constants, command codes and the memory request type of the page framebuffer engine.
`timescale 1ns / 1ps

package pfb_pkg;

  // Default store geometry.
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 64;

  // Field widths.
  localparam int BYTE_W     = 8;
  localparam int FUNC_W     = 3;
  localparam int COORD_W    = 8;
  localparam int PAGE_W     = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int WIDTH_W    = 8;
  localparam int HEIGHT_W   = 7;
  // Widest store address over the legal geometry (8 pages of 256 columns).
  localparam int ADDR_MAX_W = 11;

  // Command codes.
  localparam logic [FUNC_W-1:0] FN_PIXEL = 3'd0;
  localparam logic [FUNC_W-1:0] FN_BLIT  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FILL  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;

  // Result status codes.
  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 8'd1;

  // Register reset values.
  localparam logic [WIDTH_W-1:0]  PANEL_WIDTH_RST  = 8'd128;
  localparam logic [HEIGHT_W-1:0] PANEL_HEIGHT_RST = 7'd64;

  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic [ADDR_MAX_W-1:0] addr;
    logic [BYTE_W-1:0]     wdata;
  } pfb_mem_req_t;

endpackage

// ===== design/pfb_store.sv =====
// Frame store: single-port synchronous byte memory with registered read data.
`timescale 1ns / 1ps

module pfb_store #(
  parameter int MAX_WIDTH  = pfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pfb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  pfb_pkg::pfb_mem_req_t        mem_req,
  output logic [pfb_pkg::BYTE_W-1:0]   mem_rdata
);
  import pfb_pkg::*;

  localparam int PAGE_COUNT  = (MAX_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PAGE_COUNT * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.addr[ADDR_W-1:0]] <= mem_req.wdata;
    end
    if (mem_req.rd_en) begin
      rdata_r <= mem[mem_req.addr[ADDR_W-1:0]];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

// ===== design/pfb_seq.sv =====
// Command sequencer: decodes commands and drives read-modify-write passes over the frame store.
`timescale 1ns / 1ps

module pfb_seq #(
  parameter int MAX_WIDTH  = pfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pfb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfb_pkg::FUNC_W-1:0]    in_func,
  input  logic [pfb_pkg::COORD_W-1:0]   in_col_x,
  input  logic [pfb_pkg::COORD_W-1:0]   in_row_y,
  input  logic [pfb_pkg::COORD_W-1:0]   in_end_col,
  input  logic [pfb_pkg::COORD_W-1:0]   in_end_row,
  input  logic                          in_ink,
  input  logic [pfb_pkg::BYTE_W-1:0]    in_pattern,
  input  logic [pfb_pkg::BYTE_W-1:0]    in_mask,
  input  logic [pfb_pkg::PAGE_W-1:0]    in_page,
  input  logic [pfb_pkg::WIDTH_W-1:0]   panel_width,
  input  logic [pfb_pkg::HEIGHT_W-1:0]  panel_height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [pfb_pkg::BYTE_W-1:0]    out_read_data,
  output pfb_pkg::pfb_mem_req_t         mem_req,
  input  logic [pfb_pkg::BYTE_W-1:0]    mem_rdata
);
  import pfb_pkg::*;

  localparam int PAGE_COUNT  = (MAX_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PAGE_COUNT * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE,
    S_CAPTURE,
    S_REPLY
  } state_t;

  typedef enum logic [1:0] {
    M_BYTES,
    M_FILL,
    M_READ
  } mode_t;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic                second_r, second_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [PAGE_W-1:0]   page_last_r, page_last_nxt;
  logic [COORD_W-1:0]  col_r, col_nxt;
  logic [COORD_W-1:0]  col_first_r, col_first_nxt;
  logic [COORD_W-1:0]  col_last_r, col_last_nxt;
  logic [5:0]          row_lo_r, row_lo_nxt;
  logic [5:0]          row_hi_r, row_hi_nxt;
  logic [BYTE_W-1:0]   mask_r, mask_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic [BYTE_W-1:0]   hi_mask_r, hi_mask_nxt;
  logic [BYTE_W-1:0]   hi_data_r, hi_data_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                clr_reply_r, clr_reply_nxt;
  logic                res_status_r, res_status_nxt;
  logic [BYTE_W-1:0]   res_data_r, res_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_status_nxt;
  logic [BYTE_W-1:0]   out_read_data_r, out_read_data_nxt;

  // Effective panel size, clamped to the store geometry.
  logic [8:0]          eff_w, wm1;
  logic [HEIGHT_W-1:0] eff_h, hm1;
  logic                col_off, row_off, page_off;
  logic [COORD_W-1:0]  ex_c, ey_c;
  logic                fill_empty;
  logic [3:0]          blit_hi_page;
  logic [15:0]         blit_m16, blit_p16;
  logic [BYTE_W-1:0]   blit_vlo, blit_vhi;
  logic [BYTE_W-1:0]   fill_mask;
  logic [BYTE_W-1:0]   cur_mask, cur_data, merged;
  logic [ADDR_W-1:0]   addr_cur;

  assign eff_w = ({1'b0, panel_width} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {1'b0, panel_width};
  assign eff_h = (panel_height > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : panel_height;
  assign wm1   = eff_w - 9'd1;
  assign hm1   = eff_h - 7'd1;

  assign col_off  = {1'b0, in_col_x} >= eff_w;
  assign row_off  = in_row_y >= {1'b0, eff_h};
  assign page_off = {1'b0, in_page, 3'b000} >= eff_h;

  // Clamp fill ends to the last visible column and row.
  assign ex_c = ({1'b0, in_end_col} > wm1) ? wm1[COORD_W-1:0] : in_end_col;
  assign ey_c = (in_end_row > {1'b0, hm1}) ? {1'b0, hm1} : in_end_row;
  assign fill_empty = (ex_c < in_col_x) || (ey_c < in_row_y);

  // Blit byte spans up to two pages; rows at or past the height are dropped.
  assign blit_m16     = {8'd0, in_mask} << in_row_y[2:0];
  assign blit_p16     = {8'd0, in_pattern} << in_row_y[2:0];
  assign blit_hi_page = {1'b0, in_row_y[5:3]} + 4'd1;

  always_comb begin
    for (int j = 0; j < BYTE_W; j++) begin
      blit_vlo[j]  = {1'b0, in_row_y[5:3], 3'(j)} < eff_h;
      blit_vhi[j]  = {blit_hi_page, 3'(j)} < eff_h;
      fill_mask[j] = ({page_r, 3'(j)} >= row_lo_r) && ({page_r, 3'(j)} <= row_hi_r);
    end
  end

  assign cur_mask = (mode_r == M_FILL) ? fill_mask : (second_r ? hi_mask_r : mask_r);
  assign cur_data = second_r ? hi_data_r : data_r;
  assign merged   = (mem_rdata & ~cur_mask) | (cur_data & cur_mask);
  assign addr_cur = ADDR_W'(32'(page_r) * MAX_WIDTH + 32'(col_r));

  always_comb begin
    state_nxt         = state_r;
    mode_nxt          = mode_r;
    second_nxt        = second_r;
    page_nxt          = page_r;
    page_last_nxt     = page_last_r;
    col_nxt           = col_r;
    col_first_nxt     = col_first_r;
    col_last_nxt      = col_last_r;
    row_lo_nxt        = row_lo_r;
    row_hi_nxt        = row_hi_r;
    mask_nxt          = mask_r;
    data_nxt          = data_r;
    hi_mask_nxt       = hi_mask_r;
    hi_data_nxt       = hi_data_r;
    clr_cnt_nxt       = clr_cnt_r;
    clr_reply_nxt     = clr_reply_r;
    res_status_nxt    = res_status_r;
    res_data_nxt      = res_data_r;
    out_status_nxt    = out_status_r;
    out_read_data_nxt = out_read_data_r;
    out_valid_nxt     = out_valid_r & ~out_ready;

    mem_req.rd_en = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.addr  = ADDR_MAX_W'(addr_cur);
    mem_req.wdata = merged;

    unique case (state_r)
      S_CLEAR: begin
        // Sweep zeros through the store, one byte a cycle.
        mem_req.wr_en = 1'b1;
        mem_req.addr  = ADDR_MAX_W'(clr_cnt_r);
        mem_req.wdata = '0;
        clr_cnt_nxt   = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          clr_cnt_nxt    = '0;
          res_status_nxt = ST_DONE;
          res_data_nxt   = '0;
          state_nxt      = clr_reply_r ? S_REPLY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = ST_DONE;
          res_data_nxt   = '0;
          second_nxt     = 1'b0;
          state_nxt      = S_REPLY;
          case (in_func)
            FN_PIXEL: begin
              if (col_off || row_off) begin
                res_status_nxt = ST_REJECT;
              end else begin
                mode_nxt    = M_BYTES;
                page_nxt    = in_row_y[5:3];
                col_nxt     = in_col_x;
                mask_nxt    = 8'd1 << in_row_y[2:0];
                data_nxt    = {BYTE_W{in_ink}};
                hi_mask_nxt = '0;
                hi_data_nxt = '0;
                state_nxt   = S_READ;
              end
            end
            FN_BLIT: begin
              if (!col_off && !row_off) begin
                mode_nxt    = M_BYTES;
                page_nxt    = in_row_y[5:3];
                col_nxt     = in_col_x;
                mask_nxt    = blit_m16[7:0] & blit_vlo;
                data_nxt    = blit_p16[7:0];
                hi_mask_nxt = blit_m16[15:8] & blit_vhi;
                hi_data_nxt = blit_p16[15:8];
                state_nxt   = S_READ;
              end
            end
            FN_FILL: begin
              if (col_off || row_off) begin
                res_status_nxt = ST_REJECT;
              end else if (!fill_empty) begin
                mode_nxt      = M_FILL;
                page_nxt      = in_row_y[5:3];
                page_last_nxt = ey_c[5:3];
                col_nxt       = in_col_x;
                col_first_nxt = in_col_x;
                col_last_nxt  = ex_c;
                row_lo_nxt    = in_row_y[5:0];
                row_hi_nxt    = ey_c[5:0];
                data_nxt      = {BYTE_W{in_ink}};
                state_nxt     = S_READ;
              end
            end
            FN_READ: begin
              if (col_off || page_off) begin
                res_status_nxt = ST_REJECT;
              end else begin
                mode_nxt  = M_READ;
                page_nxt  = in_page;
                col_nxt   = in_col_x;
                state_nxt = S_READ;
              end
            end
            FN_CLEAR: begin
              clr_cnt_nxt   = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLEAR;
            end
            default: begin
              state_nxt = S_REPLY;
            end
          endcase
        end
      end
      S_READ: begin
        mem_req.rd_en = 1'b1;
        state_nxt     = (mode_r == M_READ) ? S_CAPTURE : S_WRITE;
      end
      S_CAPTURE: begin
        res_data_nxt = mem_rdata;
        state_nxt    = S_REPLY;
      end
      S_WRITE: begin
        // Write back the merged byte, then advance to the next one if any remain, else reply.
        mem_req.wr_en = 1'b1;
        state_nxt     = S_REPLY;
        if (mode_r == M_FILL) begin
          if (col_r != col_last_r) begin
            col_nxt   = col_r + 1'b1;
            state_nxt = S_READ;
          end else if (page_r != page_last_r) begin
            page_nxt  = page_r + 1'b1;
            col_nxt   = col_first_r;
            state_nxt = S_READ;
          end
        end else if (!second_r && (hi_mask_r != '0)) begin
          second_nxt = 1'b1;
          page_nxt   = page_r + 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_REPLY: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = res_status_r;
          out_read_data_nxt = res_data_r;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= M_BYTES;
      second_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      second_r    <= second_nxt;
    end
    page_r          <= page_nxt;
    page_last_r     <= page_last_nxt;
    col_r           <= col_nxt;
    col_first_r     <= col_first_nxt;
    col_last_r      <= col_last_nxt;
    row_lo_r        <= row_lo_nxt;
    row_hi_r        <= row_hi_nxt;
    mask_r          <= mask_nxt;
    data_r          <= data_nxt;
    hi_mask_r       <= hi_mask_nxt;
    hi_data_r       <= hi_data_nxt;
    res_status_r    <= res_status_nxt;
    res_data_r      <= res_data_nxt;
    out_status_r    <= out_status_nxt;
    out_read_data_r <= out_read_data_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;

endmodule

// ===== design/page_framebuffer_draw_engine.sv =====
// Top level of the page framebuffer draw engine: panel registers, sequencer and frame store.
// Flow: a rejected, empty or unknown command is answered at once; a pixel, read or blit
//   reads each touched byte, then merges and writes it back (a read captures it instead),
//   a fill walks its bytes column by column and page by page, and a clear sweeps the store.
// Throughput: one command at a time; the next is taken once the result has been posted.
// Reset: synchronous active-low; sweeps zeros through the store before any work.
`timescale 1ns / 1ps

module page_framebuffer_draw_engine #(
  parameter int MAX_WIDTH  = pfb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pfb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfb_pkg::BYTE_W-1:0]    cfg_data,
  // Command channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfb_pkg::FUNC_W-1:0]    in_func,
  input  logic [pfb_pkg::COORD_W-1:0]   in_col_x,
  input  logic [pfb_pkg::COORD_W-1:0]   in_row_y,
  input  logic [pfb_pkg::COORD_W-1:0]   in_end_col,
  input  logic [pfb_pkg::COORD_W-1:0]   in_end_row,
  input  logic                          in_ink,
  input  logic [pfb_pkg::BYTE_W-1:0]    in_pattern,
  input  logic [pfb_pkg::BYTE_W-1:0]    in_mask,
  input  logic [pfb_pkg::PAGE_W-1:0]    in_page,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [pfb_pkg::BYTE_W-1:0]    out_read_data
);
  import pfb_pkg::*;

  logic [WIDTH_W-1:0]  panel_width_r, panel_width_nxt;
  logic [HEIGHT_W-1:0] panel_height_r, panel_height_nxt;
  pfb_mem_req_t        mem_req;
  logic [BYTE_W-1:0]   mem_rdata;

  // Registers are always writable; the panel size is only sampled as a command is taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    panel_width_nxt  = panel_width_r;
    panel_height_nxt = panel_height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PANEL_WIDTH:  panel_width_nxt  = cfg_data;
        REG_PANEL_HEIGHT: panel_height_nxt = cfg_data[HEIGHT_W-1:0];
        default: begin
          // Drop writes to indexes beyond the register list.
          panel_width_nxt = panel_width_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r  <= PANEL_WIDTH_RST;
      panel_height_r <= PANEL_HEIGHT_RST;
    end else begin
      panel_width_r  <= panel_width_nxt;
      panel_height_r <= panel_height_nxt;
    end
  end

  // Sequencer: decode, bound checks, byte walk and result register.
  pfb_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_col_x       (in_col_x),
    .in_row_y       (in_row_y),
    .in_end_col     (in_end_col),
    .in_end_row     (in_end_row),
    .in_ink         (in_ink),
    .in_pattern     (in_pattern),
    .in_mask        (in_mask),
    .in_page        (in_page),
    .panel_width    (panel_width_r),
    .panel_height   (panel_height_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  // Frame store: page-major bytes, one access per cycle, registered read data.
  pfb_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== bench/pfb_draw_checker.sv =====
// Checker for the page framebuffer draw engine: shadow store, result prediction and compare.
`timescale 1ns / 1ps

module pfb_draw_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfb_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [pfb_pkg::FUNC_W-1:0]    in_func,
  input  logic [pfb_pkg::COORD_W-1:0]   in_col_x,
  input  logic [pfb_pkg::COORD_W-1:0]   in_row_y,
  input  logic [pfb_pkg::COORD_W-1:0]   in_end_col,
  input  logic [pfb_pkg::COORD_W-1:0]   in_end_row,
  input  logic                          in_ink,
  input  logic [pfb_pkg::BYTE_W-1:0]    in_pattern,
  input  logic [pfb_pkg::BYTE_W-1:0]    in_mask,
  input  logic [pfb_pkg::PAGE_W-1:0]    in_page,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_status,
  input  logic [pfb_pkg::BYTE_W-1:0]    out_read_data,
  output int                            pending,
  output int                            mismatches,
  output int                            checked,
  output int                            rejects
);
  import pfb_pkg::*;

  localparam int FB_COLS  = DEF_MAX_WIDTH;
  localparam int FB_ROWS  = DEF_MAX_HEIGHT;
  localparam int FB_PAGES = (FB_ROWS + 7) / 8;
  localparam int FB_BYTES = FB_PAGES * FB_COLS;

  typedef struct {
    int                seq;
    logic [FUNC_W-1:0] func;
    logic              status;
    logic [BYTE_W-1:0] read_data;
  } draw_result_t;

  logic [BYTE_W-1:0] frame_shadow [FB_BYTES];
  int                panel_w;
  int                panel_h;
  int                cmd_seq;
  int                fail_tally;
  draw_result_t      expected_results [$];

  task automatic report_mismatch(input string what, input int seq, input int got,
                                 input int want);
    fail_tally++;
    $display("[%0t] mismatch on command %0d: %s, got 0x%0h, wanted 0x%0h",
             $time, seq, what, got, want);
  endtask

  task automatic plot_pixel(input int x, input int y, input logic v);
    int idx;
    idx = (y >> 3) * FB_COLS + x;
    if (idx < FB_BYTES) begin
      if (v) frame_shadow[idx] = frame_shadow[idx] | (8'd1 << (y & 7));
      else   frame_shadow[idx] = frame_shadow[idx] & ~(8'd1 << (y & 7));
    end
  endtask

  task automatic wipe_shadow();
    for (int i = 0; i < FB_BYTES; i++) frame_shadow[i] = '0;
  endtask

  // Apply one command to the shadow store and work out its status and read byte.
  task automatic predict_command(input logic [FUNC_W-1:0] fn, input int cx, input int ry,
                                 input int ex, input int ey, input logic pv,
                                 input logic [BYTE_W-1:0] pat, input logic [BYTE_W-1:0] msk,
                                 input int pg, output logic st, output logic [BYTE_W-1:0] rd);
    int   w;
    int   h;
    int   yp;
    int   last_x;
    int   last_y;
    logic past_bottom;
    w  = (panel_w > FB_COLS) ? FB_COLS : panel_w;
    h  = (panel_h > FB_ROWS) ? FB_ROWS : panel_h;
    st = ST_DONE;
    rd = '0;
    case (fn)
      FN_PIXEL: begin
        if (cx >= w || ry >= h) st = ST_REJECT;
        else plot_pixel(cx, ry, pv);
      end
      FN_BLIT: begin
        if (cx < w) begin
          past_bottom = 1'b0;
          for (int k = 0; k < 8; k++) begin
            yp = (ry + k) & 255;
            if (yp >= h) past_bottom = 1'b1;
            if (!past_bottom && msk[k]) plot_pixel(cx, yp, pat[k]);
          end
        end
      end
      FN_FILL: begin
        if (cx >= w || ry >= h) begin
          st = ST_REJECT;
        end else begin
          last_x = (ex > w - 1) ? w - 1 : ex;
          last_y = (ey > h - 1) ? h - 1 : ey;
          for (int y = ry; y <= last_y; y++)
            for (int x = cx; x <= last_x; x++) plot_pixel(x, y, pv);
        end
      end
      FN_READ: begin
        if (cx >= w || pg * 8 >= h) st = ST_REJECT;
        else if (pg * FB_COLS + cx < FB_BYTES) rd = frame_shadow[pg * FB_COLS + cx];
      end
      FN_CLEAR: wipe_shadow();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    draw_result_t     want;
    logic             st;
    logic [BYTE_W-1:0] rd;
    if (!rst_n) begin
      wipe_shadow();
      panel_w = PANEL_WIDTH_RST;
      panel_h = PANEL_HEIGHT_RST;
      cmd_seq = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no command outstanding", -1, out_read_data, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", want.seq, out_status, want.status);
          if (out_read_data !== want.read_data)
            report_mismatch("read data", want.seq, out_read_data, want.read_data);
          if (want.status == ST_REJECT) rejects <= rejects + 1;
          checked <= checked + 1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PANEL_WIDTH) panel_w = cfg_data;
        else if (cfg_index == REG_PANEL_HEIGHT) panel_h = cfg_data[HEIGHT_W-1:0];
      end
      if (in_valid && in_ready) begin
        predict_command(in_func, in_col_x, in_row_y, in_end_col, in_end_row, in_ink,
                        in_pattern, in_mask, in_page, st, rd);
        want.seq       = cmd_seq;
        want.func      = in_func;
        want.status    = st;
        want.read_data = rd;
        expected_results.push_back(want);
        cmd_seq++;
      end
    end
    pending    <= expected_results.size();
    mismatches <= fail_tally;
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the page framebuffer draw engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
  import pfb_pkg::*;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_TAIL      = 40;
  localparam int PHASE_SETTLE    = 4;
  localparam int N_PHASES        = 10;
  // Codes above the clear command do nothing but still answer.
  localparam logic [FUNC_W-1:0]    FN_FIRST_UNUSED = 3'd5;
  // No register lives at this index: writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED    = 8'hFF;

  typedef enum int {FLOW_FREE, FLOW_TX_GAPS, FLOW_RX_STALLS, FLOW_BOTH} flow_mode_t;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] col_x;
    logic [COORD_W-1:0] row_y;
    logic [COORD_W-1:0] end_col;
    logic [COORD_W-1:0] end_row;
    logic               ink;
    logic [BYTE_W-1:0]  pattern;
    logic [BYTE_W-1:0]  mask;
    logic [PAGE_W-1:0]  page;
  } draw_cmd_t;

  // Every input starts at a known value.
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [BYTE_W-1:0]    cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic [FUNC_W-1:0]    in_func        = '0;
  logic [COORD_W-1:0]   in_col_x       = '0;
  logic [COORD_W-1:0]   in_row_y       = '0;
  logic [COORD_W-1:0]   in_end_col     = '0;
  logic [COORD_W-1:0]   in_end_row     = '0;
  logic                 in_ink         = 1'b0;
  logic [BYTE_W-1:0]    in_pattern     = '0;
  logic [BYTE_W-1:0]    in_mask        = '0;
  logic [PAGE_W-1:0]    in_page        = '0;
  logic                 out_ready      = 1'b0;
  logic                 cfg_ready;
  logic                 in_ready;
  logic                 out_valid;
  logic                 out_status;
  logic [BYTE_W-1:0]    out_read_data;

  int pending;
  int mismatches;
  int checked;
  int rejects;

  int   cycle_count  = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic squeeze_req  = 1'b0;
  logic squeeze_done = 1'b0;
  int   hold_left    = 0;
  int   cmds_sent    = 0;
  int   unused_sent  = 0;
  int   reg_writes   = 0;

  always #10 clk = ~clk;

  page_framebuffer_draw_engine uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_col_x      (in_col_x),
    .in_row_y      (in_row_y),
    .in_end_col    (in_end_col),
    .in_end_row    (in_end_row),
    .in_ink        (in_ink),
    .in_pattern    (in_pattern),
    .in_mask       (in_mask),
    .in_page       (in_page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

  pfb_draw_checker draw_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_col_x      (in_col_x),
    .in_row_y      (in_row_y),
    .in_end_col    (in_end_col),
    .in_end_row    (in_end_row),
    .in_ink        (in_ink),
    .in_pattern    (in_pattern),
    .in_mask       (in_mask),
    .in_page       (in_page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_read_data (out_read_data),
    .pending       (pending),
    .mismatches    (mismatches),
    .checked       (checked),
    .rejects       (rejects)
  );

  // Bound the run: a hung handshake must not spin forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side. Stall at the current rate, except during the one long hold-off, which
  // counts its own cycles so that the engine backs up and drops in_ready meanwhile.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_OFF_CYCLES - 1;
      squeeze_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic draw_cmd_t make_cmd(logic [FUNC_W-1:0] fn, int cx, int ry, int ec, int er,
                                         logic pv, logic [BYTE_W-1:0] pat,
                                         logic [BYTE_W-1:0] msk, int pg);
    draw_cmd_t c;
    c.func    = fn;
    c.col_x   = COORD_W'(cx);
    c.row_y   = COORD_W'(ry);
    c.end_col = COORD_W'(ec);
    c.end_row = COORD_W'(er);
    c.ink     = pv;
    c.pattern = pat;
    c.mask    = msk;
    c.page    = PAGE_W'(pg);
    return c;
  endfunction

  // Mostly land inside the visible panel, now and then anywhere in the field's range.
  function automatic int pick_coord(int lim);
    if (lim > 0 && $urandom_range(99) < 85) return $urandom_range(lim - 1);
    return $urandom_range(255);
  endfunction

  // Offer one command and hold it until taken. Valid is only lowered for an idle gap,
  // so a back-to-back transaction never sees valid dropped and raised in one step.
  task automatic send_cmd(input draw_cmd_t c);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < tx_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= c.func;
    in_col_x   <= c.col_x;
    in_row_y   <= c.row_y;
    in_end_col <= c.end_col;
    in_end_row <= c.end_row;
    in_ink     <= c.ink;
    in_pattern <= c.pattern;
    in_mask    <= c.mask;
    in_page    <= c.page;
    do @(posedge clk); while (in_ready !== 1'b1);
    cmds_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Stop offering and wait for every outstanding result, then let the engine settle.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    draw_cmd_t  c;
    flow_mode_t mode;
    int         pw;
    int         ph;
    int         cur_w;
    int         cur_h;
    int         items;
    int         counted;
    int         r;
    int         ec;
    int         er;

    // Hold reset before releasing it; the engine then sweeps its store before taking work.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands at the reset geometry (128 x 64).
    send_cmd(make_cmd(FN_PIXEL, 0, 0, 0, 0, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_PIXEL, 127, 63, 255, 255, 1'b1, 8'hFF, 8'hFF, 7));
    send_cmd(make_cmd(FN_READ, 127, 0, 0, 0, 1'b0, 8'h00, 8'h00, 7));
    send_cmd(make_cmd(FN_PIXEL, 127, 63, 0, 0, 1'b0, 8'h00, 8'h00, 0));
    // Pixels at or past the right and bottom edges are rejected.
    send_cmd(make_cmd(FN_PIXEL, 128, 0, 0, 0, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_PIXEL, 0, 64, 0, 0, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_PIXEL, 255, 255, 0, 0, 1'b1, 8'h00, 8'h00, 0));
    // Blits: cut at the bottom row, top row far below the panel, off-panel column,
    // a byte that straddles two pages, and an empty mask.
    send_cmd(make_cmd(FN_BLIT, 5, 60, 0, 0, 1'b0, 8'hA5, BYTE_ONES, 0));
    send_cmd(make_cmd(FN_BLIT, 6, 250, 0, 0, 1'b0, 8'hFF, 8'h0F, 0));
    send_cmd(make_cmd(FN_BLIT, 7, 3, 0, 0, 1'b0, 8'h5A, 8'h5A, 0));
    send_cmd(make_cmd(FN_BLIT, 128, 0, 0, 0, 1'b0, 8'hFF, BYTE_ONES, 0));
    send_cmd(make_cmd(FN_BLIT, 8, 0, 0, 0, 1'b0, 8'hFF, 8'h00, 0));
    send_cmd(make_cmd(FN_READ, 5, 0, 0, 0, 1'b0, 8'h00, 8'h00, 7));
    send_cmd(make_cmd(FN_READ, 7, 0, 0, 0, 1'b0, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_READ, 7, 0, 0, 0, 1'b0, 8'h00, 8'h00, 1));
    // Fills: plain, ends clamped to the panel, end before start, start out of range.
    send_cmd(make_cmd(FN_FILL, 10, 4, 20, 12, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_FILL, 120, 56, 255, 255, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_FILL, 30, 30, 20, 20, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_FILL, 200, 0, 210, 4, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_FILL, 0, 64, 10, 70, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_READ, 15, 0, 0, 0, 1'b0, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_READ, 127, 0, 0, 0, 1'b0, 8'h00, 8'h00, 7));
    // Reads past the right edge are rejected.
    send_cmd(make_cmd(FN_READ, 128, 0, 0, 0, 1'b0, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_READ, 255, 255, 255, 255, 1'b1, 8'hFF, 8'hFF, 7));
    // Whole-panel fill, unused codes, then clear and read back.
    send_cmd(make_cmd(FN_FILL, 0, 0, 255, 255, 1'b1, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_READ, 64, 0, 0, 0, 1'b0, 8'h00, 8'h00, 3));
    send_cmd(make_cmd(FN_FIRST_UNUSED, 1, 1, 255, 255, 1'b1, 8'hFF, 8'hFF, 7));
    send_cmd(make_cmd(FN_FIRST_UNUSED + 3'd2, 0, 0, 0, 0, 1'b0, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_CLEAR, 0, 0, 0, 0, 1'b0, 8'h00, 8'h00, 0));
    send_cmd(make_cmd(FN_READ, 64, 0, 0, 0, 1'b0, 8'h00, 8'h00, 3));
    unused_sent += 2;

    for (int p = 0; p < N_PHASES; p++) begin
      // Pick the geometry, flow mode and length of this phase.
      case (p)
        0:       begin pw = 128; ph = 64;  mode = FLOW_FREE;      items = 110; end
        1:       begin pw = 37;  ph = 24;  mode = FLOW_TX_GAPS;   items = 100; end
        2:       begin pw = 1;   ph = 8;   mode = FLOW_RX_STALLS; items = 90;  end
        3:       begin pw = 255; ph = 127; mode = FLOW_BOTH;      items = 100; end
        4:       begin pw = 100; ph = 40;  mode = FLOW_FREE;      items = 100; end
        5:       begin pw = 0;   ph = 64;  mode = FLOW_BOTH;      items = 25;  end
        6:       begin pw = 128; ph = 0;   mode = FLOW_TX_GAPS;   items = 25;  end
        7:       begin pw = 64;  ph = 13;  mode = FLOW_RX_STALLS; items = 100; end
        8:       begin pw = 128; ph = 200; mode = FLOW_BOTH;      items = 50;  end
        default: begin pw = 128; ph = 64;  mode = FLOW_FREE;      items = 80;  end
      endcase

      // Registers only change once the engine has gone quiet.
      drain(PHASE_SETTLE);
      write_reg(REG_PANEL_WIDTH, BYTE_W'(pw));
      write_reg(REG_PANEL_HEIGHT, BYTE_W'(ph));
      if (p == 4) write_reg(REG_UNMAPPED, 8'h00);
      cur_w = ((pw & 8'hFF) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : (pw & 8'hFF);
      cur_h = ((ph & 7'h7F) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : (ph & 7'h7F);

      case (mode)
        FLOW_FREE:      begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        FLOW_TX_GAPS:   begin tx_idle_pct = 55; rx_stall_pct <= 0;  end
        FLOW_RX_STALLS: begin tx_idle_pct = 0;  rx_stall_pct <= 55; end
        default:        begin tx_idle_pct = 36; rx_stall_pct <= 36; end
      endcase
      // Arm the long output hold-off once, in the first stalling phase.
      if (p == 2) squeeze_req <= 1'b1;

      counted = 0;
      while (counted < items) begin
        r = $urandom_range(99);
        if (r < 24)      c.func = FN_PIXEL;
        else if (r < 48) c.func = FN_BLIT;
        else if (r < 63) c.func = FN_FILL;
        else if (r < 95) c.func = FN_READ;
        else if (r < 96) c.func = FN_CLEAR;
        else             c.func = FN_FIRST_UNUSED + 3'($urandom_range(2));
        c.col_x   = COORD_W'(pick_coord(cur_w));
        c.row_y   = COORD_W'(pick_coord(cur_h));
        c.ink     = 1'($urandom_range(1));
        c.pattern = BYTE_W'($urandom_range(255));
        c.mask    = ($urandom_range(4) == 0) ? BYTE_ONES : 8'($urandom_range(255));
        c.page    = PAGE_W'($urandom_range(7));
        ec        = $urandom_range(255);
        er        = $urandom_range(255);
        if (c.func == FN_FILL) begin
          // Keep most fills small; a few run to the edges or end before they start.
          r = $urandom_range(99);
          if (r < 75) begin
            ec = c.col_x + $urandom_range(7);
            er = c.row_y + $urandom_range(12);
          end else if (r < 90) begin
            ec = 255;
            er = (r < 85) ? er : 255;
          end else begin
            ec = c.col_x - 1 - $urandom_range(2);
            er = c.row_y;
          end
          if (ec > 255) ec = 255;
          if (ec < 0) ec = 0;
          if (er > 255) er = 255;
        end
        c.end_col = COORD_W'(ec);
        c.end_row = COORD_W'(er);
        send_cmd(c);
        if (c.func <= FN_CLEAR) counted++;
        else unused_sent++;
      end
    end

    drain(DRAIN_TAIL);
    $display("Covered %0d commands (%0d with unused codes) over %0d panel geometries,",
             cmds_sent, unused_sent, N_PHASES);
    $display("%0d results compared, %0d rejected, %0d register writes, with one long hold-off.",
             checked, rejects, reg_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
